[src/mabsg_pkg.sv]
package mabsg_pkg;

    localparam int AXES    = 6;
    localparam int BLOCKS  = 4;
    localparam int BLK_W   = 2;
    localparam int AXIS_W  = 3;
    localparam int CNT_W   = 32;
    localparam int CTR_W   = CNT_W + 1;
    localparam int POS_W   = 32;
    localparam int LINE_W  = 32;
    localparam int SEG_W   = 16;
    localparam int PER_W   = 16;
    localparam int PRE_W   = 3;
    localparam int CFG_W   = 6;
    localparam int CIDX_W  = 2;

    typedef enum logic [2:0] {
        REQ_AXIS_STEPS = 3'd0,
        REQ_HEADER     = 3'd1,
        REQ_START      = 3'd2,
        REQ_TICK       = 3'd3,
        REQ_READ_POS   = 3'd4
    } t_req;

    typedef enum logic [CIDX_W-1:0] {
        CFG_STEP_INV  = 2'd0,
        CFG_DIR_INV   = 2'd1,
        CFG_HOME_MODE = 2'd2,
        CFG_HOME_LOCK = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              steps_we;
        logic [AXIS_W-1:0] axis;
        logic              hdr_we;
        logic [BLK_W-1:0]  addr;
    } t_store_wr;

endpackage

[src/mabsg_store.sv]
module mabsg_store
    import mabsg_pkg::*;
(
    input  logic                       i_clk,
    input  t_store_wr                  i_wr,
    input  logic [CNT_W-1:0]           i_wsteps,
    input  logic [CNT_W-1:0]           i_wevents,
    input  logic [AXES-1:0]            i_wdirs,
    input  logic                       i_re,
    input  logic [BLK_W-1:0]           i_raddr,
    output logic [AXES-1:0][CNT_W-1:0] o_steps,
    output logic [CNT_W-1:0]           o_events,
    output logic [AXES-1:0]            o_dirs
);

    logic [CNT_W-1:0] r_mem_ev [BLOCKS];
    logic [AXES-1:0]  r_mem_dir [BLOCKS];
    logic [CNT_W-1:0] r_rd_ev;
    logic [AXES-1:0]  r_rd_dir;
    logic             r_byp_hdr;
    logic [CNT_W-1:0] r_byp_ev;
    logic [AXES-1:0]  r_byp_dir;

    always_ff @(posedge i_clk) begin
        if (i_wr.hdr_we) begin
            r_mem_ev[i_wr.addr]  <= i_wevents;
            r_mem_dir[i_wr.addr] <= i_wdirs;
        end
        if (i_re) begin
            r_rd_ev   <= r_mem_ev[i_raddr];
            r_rd_dir  <= r_mem_dir[i_raddr];
            r_byp_hdr <= i_wr.hdr_we && (i_wr.addr == i_raddr);
            r_byp_ev  <= i_wevents;
            r_byp_dir <= i_wdirs;
        end
    end

    assign o_events = r_byp_hdr ? r_byp_ev : r_rd_ev;
    assign o_dirs   = r_byp_hdr ? r_byp_dir : r_rd_dir;

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        logic [CNT_W-1:0] r_mem [BLOCKS];
        logic [CNT_W-1:0] r_rd;
        logic             r_byp;
        logic [CNT_W-1:0] r_byp_d;
        logic             lane_we;

        assign lane_we = i_wr.steps_we && (i_wr.axis == AXIS_W'(a));

        always_ff @(posedge i_clk) begin
            if (lane_we) begin
                r_mem[i_wr.addr] <= i_wsteps;
            end
            if (i_re) begin
                r_rd    <= r_mem[i_raddr];
                r_byp   <= lane_we && (i_wr.addr == i_raddr);
                r_byp_d <= i_wsteps;
            end
        end

        assign o_steps[a] = r_byp ? r_byp_d : r_rd;
    end

endmodule

[src/multi_axis_bresenham_step_generator.sv]
// multi-axis step generator
// input channel i_valid / o_stall carries one request per transaction: axis step
// write, block header write, segment start, tick or position read. output
// channel o_valid / i_stall returns exactly one result per request, in order.
// the synchronous block store is read at the accepting edge, and the counter
// update lands in the output register when the update stage advances. one
// request is taken every cycle while the receiver does not stall; writes to the
// block row being read are forwarded, so no request waits on another.
// when the receiver stalls, the result register holds and the request in the
// update stage waits; the input channel stalls only while that stage is full
// and cannot advance.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// synchronous reset clears counters, positions, segment state and the output
// channel, sets homing_lock to all axes; the block store is not cleared.
module multi_axis_bresenham_step_generator
    import mabsg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_req_type,
    input  logic [BLK_W-1:0]         i_block_id,
    input  logic [AXIS_W-1:0]        i_axis,
    input  logic [CNT_W-1:0]         i_axis_steps,
    input  logic [CNT_W-1:0]         i_event_count,
    input  logic [AXES-1:0]          i_direction,
    input  logic [SEG_W-1:0]         i_segment_steps,
    input  logic [LINE_W-1:0]        i_line_id,
    input  logic [PER_W-1:0]         i_period_in,
    input  logic [PRE_W-1:0]         i_prescale_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [AXES-1:0]          o_step_pat,
    output logic [AXES-1:0]          o_dir_bits,
    output logic                     o_segment_done,
    output logic                     o_cycle_stop,
    output logic                     o_line_done,
    output logic [LINE_W-1:0]        o_completed_line,
    output logic [PER_W-1:0]         o_period_out,
    output logic [PRE_W-1:0]         o_prescale_out,
    output logic signed [POS_W-1:0]  o_position,
    output logic                     o_status
);

    logic [AXES-1:0] r_step_inv, r_dir_inv, r_home_lock;
    logic            r_home_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_inv  <= '0;
            r_dir_inv   <= '0;
            r_home_mode <= 1'b0;
            r_home_lock <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_INV:  r_step_inv  <= i_cfg_data[AXES-1:0];
                CFG_DIR_INV:   r_dir_inv   <= i_cfg_data[AXES-1:0];
                CFG_HOME_MODE: r_home_mode <= i_cfg_data[0];
                CFG_HOME_LOCK: r_home_lock <= i_cfg_data[AXES-1:0];
                default: ;
            endcase
        end
    end

    // update stage
    logic              r_s1_valid;
    logic [2:0]        r_s1_req;
    logic [BLK_W-1:0]  r_s1_blk;
    logic [AXIS_W-1:0] r_s1_axis;
    logic [CNT_W-1:0]  r_s1_steps;
    logic [CNT_W-1:0]  r_s1_ev;
    logic [AXES-1:0]   r_s1_dir;
    logic [SEG_W-1:0]  r_s1_seg;
    logic [LINE_W-1:0] r_s1_line;
    logic [PER_W-1:0]  r_s1_per;
    logic [PRE_W-1:0]  r_s1_pre;

    logic s1_fire, in_fire;
    assign s1_fire = r_s1_valid && (!o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_fire;
    assign in_fire = i_valid && !o_stall;

    // segment state
    logic [CTR_W-1:0]           r_ctr [AXES];
    logic [AXES-1:0][POS_W-1:0] r_pos;
    logic              r_act, r_last_vld;
    logic [BLK_W-1:0]  r_act_blk;
    logic [SEG_W-1:0]  r_ticks;
    logic [LINE_W-1:0] r_line;
    logic [AXES-1:0]   r_pend_steps, r_pend_dirs;
    logic [PER_W-1:0]  r_per;
    logic [PRE_W-1:0]  r_pre;

    logic [CTR_W-1:0]           n_ctr [AXES];
    logic [AXES-1:0][POS_W-1:0] n_pos;
    logic              n_act, n_last_vld;
    logic [BLK_W-1:0]  n_act_blk;
    logic [SEG_W-1:0]  n_ticks;
    logic [LINE_W-1:0] n_line;
    logic [AXES-1:0]   n_pend_steps, n_pend_dirs;
    logic [PER_W-1:0]  n_per;
    logic [PRE_W-1:0]  n_pre;

    logic [AXES-1:0]   n_o_step, n_o_dir;
    logic              n_o_seg_done, n_o_cstop, n_o_ldone, n_o_status;
    logic [LINE_W-1:0] n_o_cline;
    logic [POS_W-1:0]  n_o_pos;

    t_store_wr                  st_wr;
    logic [AXES-1:0][CNT_W-1:0] st_steps;
    logic [CNT_W-1:0]           st_ev;
    logic [AXES-1:0]            st_dirs;
    logic [BLK_W-1:0]           st_raddr;

    assign st_wr.steps_we = s1_fire && (r_s1_req == REQ_AXIS_STEPS)
                            && (r_s1_axis < AXIS_W'(AXES));
    assign st_wr.axis     = r_s1_axis;
    assign st_wr.hdr_we   = s1_fire && (r_s1_req == REQ_HEADER);
    assign st_wr.addr     = r_s1_blk;
    assign st_raddr = (i_req_type == REQ_TICK) ? n_act_blk : i_block_id;

    mabsg_store u_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_wsteps  (r_s1_steps),
        .i_wevents (r_s1_ev),
        .i_wdirs   (r_s1_dir),
        .i_re      (in_fire),
        .i_raddr   (st_raddr),
        .o_steps   (st_steps),
        .o_events  (st_ev),
        .o_dirs    (st_dirs)
    );

    logic [CTR_W-1:0] sum [AXES];
    logic [AXES-1:0]  bits;
    logic [SEG_W-1:0] tdec;

    always_comb begin
        n_ctr        = r_ctr;
        n_pos        = r_pos;
        n_act        = r_act;
        n_last_vld   = r_last_vld;
        n_act_blk    = r_act_blk;
        n_ticks      = r_ticks;
        n_line       = r_line;
        n_pend_steps = r_pend_steps;
        n_pend_dirs  = r_pend_dirs;
        n_per        = r_per;
        n_pre        = r_pre;
        n_o_step     = '0;
        n_o_dir      = '0;
        n_o_seg_done = 1'b0;
        n_o_cstop    = 1'b0;
        n_o_ldone    = 1'b0;
        n_o_status   = 1'b0;
        n_o_cline    = '0;
        n_o_pos      = '0;
        bits         = '0;
        tdec         = '0;
        for (int a = 0; a < AXES; a++) begin
            sum[a] = r_ctr[a] + {1'b0, st_steps[a]};
        end
        if (s1_fire) begin
            if (r_s1_req == REQ_START) begin
                if (r_act) begin
                    n_o_status = 1'b1;
                end else begin
                    if (r_s1_line != r_line) begin
                        n_o_ldone = 1'b1;
                        n_o_cline = r_line;
                    end
                    n_line  = r_s1_line;
                    n_per   = r_s1_per;
                    n_pre   = r_s1_pre;
                    n_ticks = r_s1_seg;
                    if (!r_last_vld || (r_act_blk != r_s1_blk)) begin
                        for (int a = 0; a < AXES; a++) begin
                            n_ctr[a] = {2'b00, st_ev[CNT_W-1:1]};
                        end
                    end
                    n_last_vld  = 1'b1;
                    n_act_blk   = r_s1_blk;
                    n_act       = 1'b1;
                    n_pend_dirs = st_dirs ^ r_dir_inv;
                end
            end else if (r_s1_req == REQ_TICK) begin
                n_o_step = r_pend_steps;
                n_o_dir  = r_pend_dirs;
                if (!r_act) begin
                    n_o_cstop = 1'b1;
                    n_o_ldone = 1'b1;
                    n_o_cline = r_line;
                end else begin
                    for (int a = 0; a < AXES; a++) begin
                        if (sum[a] > {1'b0, st_ev}) begin
                            bits[a]  = 1'b1;
                            n_ctr[a] = sum[a] - {1'b0, st_ev};
                            n_pos[a] = st_dirs[a] ? r_pos[a] - POS_W'(1)
                                                  : r_pos[a] + POS_W'(1);
                        end else begin
                            n_ctr[a] = sum[a];
                        end
                    end
                    if (r_home_mode) begin
                        bits = bits & r_home_lock;
                    end
                    tdec = (r_ticks != '0) ? r_ticks - SEG_W'(1) : r_ticks;
                    n_ticks = tdec;
                    if (tdec == '0) begin
                        n_act        = 1'b0;
                        n_o_seg_done = 1'b1;
                    end
                    n_pend_steps = bits ^ r_step_inv;
                end
            end else if (r_s1_req == REQ_READ_POS) begin
                if (r_s1_axis < AXIS_W'(AXES)) begin
                    n_o_pos = r_pos[r_s1_axis];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            o_valid      <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_ctr[a] <= '0;
            end
            r_pos        <= '0;
            r_act        <= 1'b0;
            r_last_vld   <= 1'b0;
            r_act_blk    <= '0;
            r_ticks      <= '0;
            r_line       <= '0;
            r_pend_steps <= '0;
            r_pend_dirs  <= '0;
            r_per        <= '0;
            r_pre        <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            r_ctr        <= n_ctr;
            r_pos        <= n_pos;
            r_act        <= n_act;
            r_last_vld   <= n_last_vld;
            r_act_blk    <= n_act_blk;
            r_ticks      <= n_ticks;
            r_line       <= n_line;
            r_pend_steps <= n_pend_steps;
            r_pend_dirs  <= n_pend_dirs;
            r_per        <= n_per;
            r_pre        <= n_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req   <= i_req_type;
            r_s1_blk   <= i_block_id;
            r_s1_axis  <= i_axis;
            r_s1_steps <= i_axis_steps;
            r_s1_ev    <= i_event_count;
            r_s1_dir   <= i_direction;
            r_s1_seg   <= i_segment_steps;
            r_s1_line  <= i_line_id;
            r_s1_per   <= i_period_in;
            r_s1_pre   <= i_prescale_in;
        end
        if (s1_fire) begin
            o_step_pat       <= n_o_step;
            o_dir_bits       <= n_o_dir;
            o_segment_done   <= n_o_seg_done;
            o_cycle_stop     <= n_o_cstop;
            o_line_done      <= n_o_ldone;
            o_completed_line <= n_o_cline;
            o_period_out     <= n_per;
            o_prescale_out   <= n_pre;
            o_position       <= n_o_pos;
            o_status         <= n_o_status;
        end
    end

endmodule

[src/mabsg_checker.sv]
module mabsg_checker
    import mabsg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic o_valid,
    input  logic i_stall,
    input  logic o_stall,
    input  logic o_segment_done,
    input  logic o_cycle_stop,
    input  logic o_status,
    input  logic o_line_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped under stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels not idle after reset");

    a_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cycle_stop && (o_segment_done || o_status)))
        else $error("cycle stop combined with other flags");

    a_stop_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cycle_stop |-> o_line_done)
        else $error("cycle stop without line report");

endmodule

bind multi_axis_bresenham_step_generator mabsg_checker u_mabsg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_stall        (o_stall),
    .o_segment_done (o_segment_done),
    .o_cycle_stop   (o_cycle_stop),
    .o_status       (o_status),
    .o_line_done    (o_line_done)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import mabsg_pkg::*;

    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 80;

    typedef struct {
        logic [2:0]        req;
        logic [BLK_W-1:0]  blk;
        logic [AXIS_W-1:0] axis;
        logic [CNT_W-1:0]  steps;
        logic [CNT_W-1:0]  events;
        logic [AXES-1:0]   dir;
        logic [SEG_W-1:0]  seg;
        logic [LINE_W-1:0] line;
        logic [PER_W-1:0]  per;
        logic [PRE_W-1:0]  pre;
    } t_request;

    typedef struct {
        logic [AXES-1:0]   step_pat;
        logic [AXES-1:0]   dir_bits;
        logic              seg_done;
        logic              cyc_stop;
        logic              line_done;
        logic [LINE_W-1:0] done_line;
        logic [PER_W-1:0]  per;
        logic [PRE_W-1:0]  pre;
        logic [POS_W-1:0]  pos;
        logic              status;
    } t_motion_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CIDX_W-1:0]       i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [2:0]              i_req_type;
    logic [BLK_W-1:0]        i_block_id;
    logic [AXIS_W-1:0]       i_axis;
    logic [CNT_W-1:0]        i_axis_steps;
    logic [CNT_W-1:0]        i_event_count;
    logic [AXES-1:0]         i_direction;
    logic [SEG_W-1:0]        i_segment_steps;
    logic [LINE_W-1:0]       i_line_id;
    logic [PER_W-1:0]        i_period_in;
    logic [PRE_W-1:0]        i_prescale_in;
    logic                    o_valid;
    logic                    i_stall;
    logic [AXES-1:0]         o_step_pat;
    logic [AXES-1:0]         o_dir_bits;
    logic                    o_segment_done;
    logic                    o_cycle_stop;
    logic                    o_line_done;
    logic [LINE_W-1:0]       o_completed_line;
    logic [PER_W-1:0]        o_period_out;
    logic [PRE_W-1:0]        o_prescale_out;
    logic signed [POS_W-1:0] o_position;
    logic                    o_status;

    multi_axis_bresenham_step_generator u_top (.*);

    // motion state mirror
    logic [CNT_W-1:0]  m_blk_steps [BLOCKS][AXES];
    logic [CNT_W-1:0]  m_blk_events [BLOCKS];
    logic [AXES-1:0]   m_blk_dirs [BLOCKS];
    logic              m_hdr_ok [BLOCKS];
    logic [AXES-1:0]   m_axis_ok [BLOCKS];
    logic [CTR_W-1:0]  m_ctr [AXES];
    logic [POS_W-1:0]  m_pos [AXES];
    logic              m_active;
    logic [BLK_W-1:0]  m_active_blk;
    logic              m_last_valid;
    logic [SEG_W-1:0]  m_ticks_left;
    logic [LINE_W-1:0] m_line;
    logic [AXES-1:0]   m_pend_steps;
    logic [AXES-1:0]   m_pend_dirs;
    logic [PER_W-1:0]  m_per;
    logic [PRE_W-1:0]  m_pre;
    logic [AXES-1:0]   c_step_inv;
    logic [AXES-1:0]   c_dir_inv;
    logic              c_home_mode;
    logic [AXES-1:0]   c_home_lock;

    t_request       request_q [$];
    t_motion_result motion_q [$];
    int unsigned    err_cnt;
    int unsigned    result_cnt;
    int unsigned    idle_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic block_ready(logic [BLK_W-1:0] b);
        return m_hdr_ok[b] && (m_axis_ok[b] == '1);
    endfunction

    task automatic predict_motion(input t_request rq);
        t_motion_result r;
        logic [AXES-1:0] bits;
        logic [CTR_W-1:0] c;
        r = '{default: '0};
        case (rq.req)
            REQ_AXIS_STEPS: begin
                if (rq.axis < AXES) begin
                    m_blk_steps[rq.blk][rq.axis] = rq.steps;
                    m_axis_ok[rq.blk][rq.axis] = 1'b1;
                end
            end
            REQ_HEADER: begin
                m_blk_events[rq.blk] = rq.events;
                m_blk_dirs[rq.blk] = rq.dir;
                m_hdr_ok[rq.blk] = 1'b1;
            end
            REQ_START: begin
                if (m_active) begin
                    r.status = 1'b1;
                end else begin
                    if (rq.line != m_line) begin
                        r.line_done = 1'b1;
                        r.done_line = m_line;
                    end
                    m_line = rq.line;
                    m_per = rq.per;
                    m_pre = rq.pre;
                    m_ticks_left = rq.seg;
                    if (!m_last_valid || m_active_blk != rq.blk) begin
                        for (int i = 0; i < AXES; i++)
                            m_ctr[i] = {1'b0, m_blk_events[rq.blk]} >> 1;
                    end
                    m_last_valid = 1'b1;
                    m_active_blk = rq.blk;
                    m_active = 1'b1;
                    m_pend_dirs = m_blk_dirs[rq.blk] ^ c_dir_inv;
                end
            end
            REQ_TICK: begin
                r.step_pat = m_pend_steps;
                r.dir_bits = m_pend_dirs;
                if (!m_active) begin
                    r.cyc_stop = 1'b1;
                    r.line_done = 1'b1;
                    r.done_line = m_line;
                end else begin
                    bits = '0;
                    for (int i = 0; i < AXES; i++) begin
                        c = m_ctr[i] + {1'b0, m_blk_steps[m_active_blk][i]};
                        if (c > {1'b0, m_blk_events[m_active_blk]}) begin
                            bits[i] = 1'b1;
                            c = c - {1'b0, m_blk_events[m_active_blk]};
                            if (m_blk_dirs[m_active_blk][i])
                                m_pos[i] = m_pos[i] - POS_W'(1);
                            else
                                m_pos[i] = m_pos[i] + POS_W'(1);
                        end
                        m_ctr[i] = c;
                    end
                    if (c_home_mode)
                        bits = bits & c_home_lock;
                    if (m_ticks_left > 0)
                        m_ticks_left = m_ticks_left - SEG_W'(1);
                    if (m_ticks_left == 0) begin
                        m_active = 1'b0;
                        r.seg_done = 1'b1;
                    end
                    m_pend_steps = bits ^ c_step_inv;
                end
            end
            REQ_READ_POS: begin
                if (rq.axis < AXES)
                    r.pos = m_pos[rq.axis];
            end
            default: ;
        endcase
        r.per = m_per;
        r.pre = m_pre;
        motion_q.push_back(r);
    endtask

    function automatic t_request random_request(logic [2:0] req);
        t_request rq;
        rq.req = req;
        rq.blk = BLK_W'($urandom_range(0, BLOCKS - 1));
        rq.axis = AXIS_W'($urandom_range(0, 7));
        rq.steps = $urandom;
        rq.events = $urandom;
        rq.dir = AXES'($urandom);
        rq.seg = SEG_W'($urandom);
        rq.line = $urandom;
        rq.per = PER_W'($urandom);
        rq.pre = PRE_W'($urandom);
        return rq;
    endfunction

    task automatic issue(input t_request rq);
        request_q.push_back(rq);
        predict_motion(rq);
    endtask

    task automatic issue_simple(input logic [2:0] req, input logic [BLK_W-1:0] b,
                                input logic [AXIS_W-1:0] ax);
        t_request rq;
        rq = random_request(req);
        rq.blk = b;
        rq.axis = ax;
        issue(rq);
    endtask

    task automatic issue_start(input logic [BLK_W-1:0] b, input logic [SEG_W-1:0] seg,
                               input logic [LINE_W-1:0] line);
        t_request rq;
        rq = random_request(REQ_START);
        rq.blk = b;
        rq.seg = seg;
        rq.line = line;
        issue(rq);
    endtask

    task automatic write_block(input logic [BLK_W-1:0] b);
        t_request rq;
        logic [CNT_W-1:0] ev;
        case ($urandom_range(0, 5))
            0: ev = $urandom;
            1: ev = '1;
            2: ev = '0;
            default: ev = $urandom_range(1, 24);
        endcase
        rq = random_request(REQ_HEADER);
        rq.blk = b;
        rq.events = ev;
        issue(rq);
        for (int i = 0; i < AXES; i++) begin
            rq = random_request(REQ_AXIS_STEPS);
            rq.blk = b;
            rq.axis = AXIS_W'(i);
            case ($urandom_range(0, 5))
                0: rq.steps = $urandom;
                1: rq.steps = '0;
                2: rq.steps = ev;
                default: rq.steps = (ev == 0) ? CNT_W'($urandom_range(0, 3))
                                              : CNT_W'($urandom % ({1'b0, ev} + 1));
            endcase
            issue(rq);
        end
    endtask

    task automatic motion_sequence();
        logic [BLK_W-1:0] b;
        int n;
        b = BLK_W'($urandom_range(0, BLOCKS - 1));
        if (!block_ready(b) || $urandom_range(0, 3) == 0)
            write_block(b);
        if (!m_active)
            issue_start(b, SEG_W'($urandom_range(0, 7)),
                        ($urandom_range(0, 2) == 0) ? m_line : LINE_W'($urandom));
        n = m_ticks_left + $urandom_range(0, 2);
        for (int i = 0; i <= n; i++) begin
            if ($urandom_range(0, 4) == 0)
                issue_simple(REQ_READ_POS, b, AXIS_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 9) == 0)
                issue_start(b, SEG_W'($urandom_range(0, 15)), $urandom);
            issue_simple(REQ_TICK, b, 0);
        end
    endtask

    task automatic noise_item();
        t_request rq;
        rq = random_request(3'($urandom_range(0, 7)));
        rq.seg = SEG_W'($urandom_range(0, 15));
        if (rq.req == REQ_START && !m_active && !block_ready(rq.blk))
            rq.req = REQ_READ_POS;
        if (rq.req == REQ_TICK && m_active && !block_ready(m_active_blk))
            rq.req = REQ_READ_POS;
        issue(rq);
    endtask

    task automatic random_phase(input int count);
        int start;
        start = request_q.size();
        while (request_q.size() - start < count) begin
            if ($urandom_range(0, 4) == 0)
                noise_item();
            else
                motion_sequence();
        end
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || i_valid || motion_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STEP_INV:  c_step_inv = val[AXES-1:0];
            CFG_DIR_INV:   c_dir_inv = val[AXES-1:0];
            CFG_HOME_MODE: c_home_mode = val[0];
            CFG_HOME_LOCK: c_home_lock = val[AXES-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // driver: bursts with random gaps
    int unsigned burst_left;
    int unsigned gap_left;
    logic        drv_next;
    t_request    drv_rq;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            drv_next = i_valid && o_stall;
            if (i_valid && !o_stall)
                idle_cycles = 0;
            if (!drv_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() > 0) begin
                    drv_rq = request_q.pop_front();
                    i_req_type <= drv_rq.req;
                    i_block_id <= drv_rq.blk;
                    i_axis <= drv_rq.axis;
                    i_axis_steps <= drv_rq.steps;
                    i_event_count <= drv_rq.events;
                    i_direction <= drv_rq.dir;
                    i_segment_steps <= drv_rq.seg;
                    i_line_id <= drv_rq.line;
                    i_period_in <= drv_rq.per;
                    i_prescale_in <= drv_rq.pre;
                    drv_next = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_valid <= drv_next;
        end
    end

    // monitor and receiver stall pattern
    int unsigned hold_left;
    int unsigned stall_mode;
    int unsigned mode_left;
    logic        stall_next;
    t_motion_result mon_exp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left = 0;
            stall_mode = 0;
            mode_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                idle_cycles = 0;
                result_cnt++;
                if (motion_q.size() == 0) begin
                    $display("unexpected transaction at %0t", $realtime);
                    err_cnt++;
                end else begin
                    mon_exp = motion_q.pop_front();
                    if (o_step_pat !== mon_exp.step_pat)
                        report("step_pat", o_step_pat, mon_exp.step_pat);
                    if (o_dir_bits !== mon_exp.dir_bits)
                        report("dir_bits", o_dir_bits, mon_exp.dir_bits);
                    if (o_segment_done !== mon_exp.seg_done)
                        report("segment_done", o_segment_done, mon_exp.seg_done);
                    if (o_cycle_stop !== mon_exp.cyc_stop)
                        report("cycle_stop", o_cycle_stop, mon_exp.cyc_stop);
                    if (o_line_done !== mon_exp.line_done)
                        report("line_done", o_line_done, mon_exp.line_done);
                    if (o_completed_line !== mon_exp.done_line)
                        report("completed_line", o_completed_line, mon_exp.done_line);
                    if (o_period_out !== mon_exp.per)
                        report("period_out", o_period_out, mon_exp.per);
                    if (o_prescale_out !== mon_exp.pre)
                        report("prescale_out", o_prescale_out, mon_exp.pre);
                    if (o_position !== mon_exp.pos)
                        report("position", o_position, mon_exp.pos);
                    if (o_status !== mon_exp.status)
                        report("status", o_status, mon_exp.status);
                end
                if (result_cnt == 300 || result_cnt == 800)
                    hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    default: stall_next = ($urandom_range(0, 1) == 0);
                endcase
            end
            i_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_request rq;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = '0;
        i_block_id = '0;
        i_axis = '0;
        i_axis_steps = '0;
        i_event_count = '0;
        i_direction = '0;
        i_segment_steps = '0;
        i_line_id = '0;
        i_period_in = '0;
        i_prescale_in = '0;
        err_cnt = 0;
        result_cnt = 0;
        idle_cycles = 0;
        c_step_inv = '0;
        c_dir_inv = '0;
        c_home_mode = 1'b0;
        c_home_lock = '1;
        for (int b = 0; b < BLOCKS; b++) begin
            m_hdr_ok[b] = 1'b0;
            m_axis_ok[b] = '0;
        end
        for (int i = 0; i < AXES; i++) begin
            m_ctr[i] = '0;
            m_pos[i] = '0;
        end
        m_active = 1'b0;
        m_active_blk = '0;
        m_last_valid = 1'b0;
        m_ticks_left = '0;
        m_line = '0;
        m_pend_steps = '0;
        m_pend_dirs = '0;
        m_per = '0;
        m_pre = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        rq = random_request(REQ_HEADER);
        rq.blk = 0;
        rq.events = 5;
        rq.dir = 6'b101010;
        issue(rq);
        for (int i = 0; i < AXES; i++) begin
            rq = random_request(REQ_AXIS_STEPS);
            rq.blk = 0;
            rq.axis = AXIS_W'(i);
            case (i)
                0: rq.steps = '0;
                1: rq.steps = 5;
                3: rq.steps = '1;
                default: rq.steps = CNT_W'(i);
            endcase
            issue(rq);
        end
        issue_simple(REQ_AXIS_STEPS, 0, 7);
        issue_simple(REQ_TICK, 0, 0);
        rq = random_request(REQ_START);
        rq.blk = 0;
        rq.seg = 0;
        rq.line = 7;
        rq.per = '1;
        rq.pre = '1;
        issue(rq);
        issue_simple(REQ_TICK, 0, 0);
        issue_simple(REQ_TICK, 0, 0);
        issue_start(0, 2, 7);
        issue_simple(REQ_TICK, 0, 0);
        issue_start(0, 9, '1);
        issue_simple(REQ_TICK, 0, 0);
        for (int i = 0; i < AXES; i++)
            issue_simple(REQ_READ_POS, 0, AXIS_W'(i));
        issue_simple(REQ_READ_POS, 0, 7);
        issue_simple(REQ_UNUSED_FIRST, 0, 0);
        issue_simple(REQ_UNUSED_LAST, 0, 0);
        random_phase(220);
        wait_drained();

        write_cfg(CFG_STEP_INV, 6'h3f);
        write_cfg(CFG_DIR_INV, 6'h2a);
        write_cfg(CFG_HOME_MODE, 6'h01);
        write_cfg(CFG_HOME_LOCK, 6'h15);
        random_phase(230);
        wait_drained();

        write_cfg(CFG_HOME_LOCK, 6'h00);
        write_cfg(CFG_DIR_INV, 6'h3f);
        random_phase(230);
        wait_drained();

        write_cfg(CFG_STEP_INV, 6'h00);
        write_cfg(CFG_DIR_INV, 6'h00);
        write_cfg(CFG_HOME_MODE, 6'h00);
        write_cfg(CFG_HOME_LOCK, 6'h3f);
        random_phase(230);
        wait_drained();

        write_cfg(CFG_STEP_INV, CFG_W'($urandom));
        write_cfg(CFG_DIR_INV, CFG_W'($urandom));
        write_cfg(CFG_HOME_MODE, CFG_W'($urandom));
        write_cfg(CFG_HOME_LOCK, CFG_W'($urandom));
        random_phase(220);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (motion_q.size() == 0 && err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
